FILE: sv/assert_macros.svh
// assertion macros for the rtl file that carries checks (lru_matrix_page_replacement)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/lrumpr_pkg.sv
// types and constants for the lru matrix page replacement block
package lrumpr_pkg;

    localparam int PROC_W      = 8;
    localparam int PAGE_W      = 8;
    localparam int FRAME_OUT_W = 3;
    localparam int FREED_W     = 4;
    localparam int FAULT_W     = 16;
    localparam int CFG_W       = 4;

    localparam logic [CFG_W-1:0]   FRAMES_RESET = 4'd8;
    localparam logic [FREED_W-1:0] FREED_MAX    = 4'd15;

    typedef enum logic {
        OP_ACCESS = 1'b0,
        OP_END    = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t           opcode;
        logic [PROC_W-1:0] process_id;
        logic [PAGE_W-1:0] page_index;
    } request_t;

    typedef struct packed {
        logic                   fault;
        logic [FRAME_OUT_W-1:0] frame;
        logic                   evicted;
        logic [PROC_W-1:0]      evicted_process;
        logic [PAGE_W-1:0]      evicted_page;
        logic [FREED_W-1:0]     freed_count;
        logic [FAULT_W-1:0]     total_faults;
    } response_t;

    // update command from the top level to the frame table
    typedef struct packed {
        logic fill;      // load a page into the selected frame
        logic free_all;  // invalidate every frame of the process
    } tbl_cmd_t;

endpackage

FILE: sv/lrumpr_ftable.sv
// frame table: valid, owner and page per frame, hit search and process release
module lrumpr_ftable
    import lrumpr_pkg::*;
#(
    parameter int FRAMES = 8,
    parameter int IDX_W  = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tbl_cmd_t          cmd,
    input  logic [PROC_W-1:0] process_id,
    input  logic [PAGE_W-1:0] page_index,
    input  logic [FRAMES-1:0] managed,
    input  logic [IDX_W-1:0]  upd_idx,
    output logic              hit,
    output logic [IDX_W-1:0]  hit_idx,
    output logic              vict_valid,
    output logic [PROC_W-1:0] vict_owner,
    output logic [PAGE_W-1:0] vict_page,
    output logic [FREED_W-1:0] freed_count
);

    localparam int CW = $clog2(FRAMES + 1);

    logic [FRAMES-1:0] valid_reg, valid_next;
    logic [PROC_W-1:0] owner_reg [FRAMES];
    logic [PAGE_W-1:0] page_reg  [FRAMES];
    logic [FRAMES-1:0] page_match;
    logic [FRAMES-1:0] proc_match;
    logic [CW-1:0]     free_cnt;
    logic [CW+FREED_W-1:0] free_cnt_ext;

    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            proc_match[i] = valid_reg[i] && (owner_reg[i] == process_id);
            page_match[i] = proc_match[i] && managed[i] && (page_reg[i] == page_index);
        end
    end

    // lowest matching frame wins
    always_comb
    begin
        hit     = |page_match;
        hit_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (page_match[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        free_cnt = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            free_cnt = free_cnt + CW'(proc_match[i]);
        end
        free_cnt_ext = (CW + FREED_W)'(free_cnt);
        if (free_cnt_ext > (CW + FREED_W)'(FREED_MAX))
        begin
            freed_count = FREED_MAX;
        end
        else
        begin
            freed_count = free_cnt_ext[FREED_W-1:0];
        end
    end

    assign vict_valid = valid_reg[upd_idx];
    assign vict_owner = owner_reg[upd_idx];
    assign vict_page  = page_reg[upd_idx];

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.free_all)
        begin
            valid_next = valid_reg & ~proc_match;
        end
        else if (cmd.fill)
        begin
            valid_next[upd_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill)
        begin
            owner_reg[upd_idx] <= process_id;
            page_reg[upd_idx]  <= page_index;
        end
    end

endmodule

FILE: sv/lrumpr_matrix.sv
// lru matrix: zero-row victim search and row set / column clear on access
module lrumpr_matrix
    import lrumpr_pkg::*;
#(
    parameter int FRAMES = 8,
    parameter int IDX_W  = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              touch,
    input  logic [IDX_W-1:0]  idx,
    input  logic [FRAMES-1:0] managed,
    output logic [IDX_W-1:0]  victim_idx
);

    logic [FRAMES-1:0] row_reg  [FRAMES];
    logic [FRAMES-1:0] row_next [FRAMES];
    logic [FRAMES-1:0] zero_row;

    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            zero_row[i] = managed[i] && ((row_reg[i] & managed) == '0);
        end
    end

    // first zero row, frame 0 when none
    always_comb
    begin
        victim_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (zero_row[i])
            begin
                victim_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            row_next[i] = row_reg[i];
            if (touch)
            begin
                if (IDX_W'(i) == idx)
                begin
                    row_next[i] = row_next[i] | managed;
                end
                if (managed[i])
                begin
                    row_next[i][idx] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                row_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                row_reg[i] <= row_next[i];
            end
        end
    end

endmodule

FILE: sv/lru_matrix_page_replacement.sv
// a transaction goes into the input register, its result into the result register that drives response with done
// throughput: one transaction per cycle, busy never rises; table and matrix update in one pass
// each transaction sees the frame table and matrix left by the one before it
// the receiver cannot stall: done is a one-cycle strobe, taken at the edge that ends it
// reset: frame table and matrix cleared, fault count zero, frames_in_use back to 8
`include "assert_macros.svh"
module lru_matrix_page_replacement
    import lrumpr_pkg::*;
#(
    parameter int FRAMES = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    // command channel
    input  logic             start,
    output logic             busy,
    input  request_t         request,
    // result strobe
    output logic             done,
    output response_t        response,
    // configuration write channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(FRAMES);

    // input register
    logic      in_valid_reg;
    request_t  in_reg;

    // configuration
    logic [CFG_W-1:0] frames_reg;

    // fault counter and result register
    logic [FAULT_W-1:0] fault_cnt_reg, fault_cnt_next;
    logic               done_reg;
    response_t          resp_reg, resp_next;

    // datapath between the registers
    logic [FRAMES-1:0] managed;
    logic              is_access;
    logic              is_end;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [IDX_W-1:0]  victim_idx;
    logic [IDX_W-1:0]  sel_idx;
    logic              vict_valid;
    logic [PROC_W-1:0] vict_owner;
    logic [PAGE_W-1:0] vict_page;
    logic [FREED_W-1:0] freed_count;
    logic              miss;
    tbl_cmd_t          tbl_cmd;
    logic [IDX_W+FRAME_OUT_W-1:0] sel_ext;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // command transaction capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_reg <= request;
        end
    end

    // frames_in_use register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= FRAMES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            frames_reg <= cfg_data;
        end
    end

    // managed frames: zero acts as one, anything beyond FRAMES is clipped
    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            managed[i] = (i == 0) || (i < int'(frames_reg));
        end
    end

    assign is_access = in_valid_reg && (in_reg.opcode == OP_ACCESS);
    assign is_end    = in_valid_reg && (in_reg.opcode == OP_END);
    assign miss      = is_access && !hit;
    assign sel_idx   = hit ? hit_idx : victim_idx;

    assign tbl_cmd.fill     = miss;
    assign tbl_cmd.free_all = is_end;

    lrumpr_ftable #(
        .FRAMES (FRAMES),
        .IDX_W  (IDX_W)
    ) u_ftable (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (tbl_cmd),
        .process_id  (in_reg.process_id),
        .page_index  (in_reg.page_index),
        .managed     (managed),
        .upd_idx     (sel_idx),
        .hit         (hit),
        .hit_idx     (hit_idx),
        .vict_valid  (vict_valid),
        .vict_owner  (vict_owner),
        .vict_page   (vict_page),
        .freed_count (freed_count)
    );

    lrumpr_matrix #(
        .FRAMES (FRAMES),
        .IDX_W  (IDX_W)
    ) u_matrix (
        .clk        (clk),
        .rst_n      (rst_n),
        .touch      (is_access),
        .idx        (sel_idx),
        .managed    (managed),
        .victim_idx (victim_idx)
    );

    // saturating fault count
    always_comb
    begin
        fault_cnt_next = fault_cnt_reg;
        if (miss && (fault_cnt_reg != '1))
        begin
            fault_cnt_next = fault_cnt_reg + FAULT_W'(1);
        end
    end

    assign sel_ext = (IDX_W + FRAME_OUT_W)'(sel_idx);

    // result assembly, unused fields forced to zero
    always_comb
    begin
        resp_next                 = '0;
        resp_next.total_faults    = fault_cnt_next;
        if (is_access)
        begin
            resp_next.fault = miss;
            resp_next.frame = sel_ext[FRAME_OUT_W-1:0];
            if (miss && vict_valid)
            begin
                resp_next.evicted         = 1'b1;
                resp_next.evicted_process = vict_owner;
                resp_next.evicted_page    = vict_page;
            end
        end
        else if (is_end)
        begin
            resp_next.freed_count = freed_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_cnt_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            fault_cnt_reg <= fault_cnt_next;
            done_reg      <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            resp_reg <= resp_next;
        end
    end

    assign done     = done_reg;
    assign response = resp_reg;

    // every captured transaction yields a strobe on the next cycle
    `ASSERT_NEXT(a_done_follows, clk, rst_n, in_valid_reg, done)
    // an eviction only happens on a fault
    `ASSERT_SAME(a_evict_on_fault, clk, rst_n, done && response.evicted, response.fault)
    // a fault always leaves a nonzero running count
    `ASSERT_SAME(a_fault_counted, clk, rst_n, done && response.fault, response.total_faults != '0)
    // the count holds once saturated
    `ASSERT_NEXT(a_count_sat, clk, rst_n, fault_cnt_reg == '1, fault_cnt_reg == '1)

endmodule

FILE: tb/lru_frame_checker.sv
`timescale 1ns / 100ps
// checker that predicts frame table and lru matrix behavior and compares every response
module lru_frame_checker
    import lrumpr_pkg::*;
#(
    parameter int FRAMES = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  request_t         request,
    input  logic             done,
    input  response_t        response,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    output int               outstanding,
    output int               mismatches
);

    localparam int REPORT_MAX = 40;

    logic               slot_valid [FRAMES];
    logic [PROC_W-1:0]  slot_owner [FRAMES];
    logic [PAGE_W-1:0]  slot_page  [FRAMES];
    logic [FRAMES-1:0]  recency    [FRAMES];
    logic [FAULT_W-1:0] fault_tally;
    logic [CFG_W-1:0]   frames_setting;
    response_t          expected_responses [$];
    int                 error_tally;

    // advances the frame table and matrix by one request and returns its response
    function automatic response_t next_response(request_t req);
        response_t         rsp;
        int                managed;
        int                freed;
        int                slot;
        logic              hit;
        logic              found;
        logic [FRAMES-1:0] cols;
        rsp = '0;
        if (req.opcode == OP_END)
        begin
            freed = 0;
            for (int i = 0; i < FRAMES; i++)
            begin
                if (slot_valid[i] && slot_owner[i] == req.process_id)
                begin
                    slot_valid[i] = 1'b0;
                    freed++;
                end
            end
            rsp.freed_count = (freed > int'(FREED_MAX)) ? FREED_MAX : FREED_W'(freed);
        end
        else
        begin
            if (frames_setting == '0)
                managed = 1;
            else if (int'(frames_setting) > FRAMES)
                managed = FRAMES;
            else
                managed = int'(frames_setting);
            cols = '0;
            for (int i = 0; i < managed; i++)
                cols[i] = 1'b1;
            hit  = 1'b0;
            slot = 0;
            for (int i = 0; i < managed; i++)
            begin
                if (!hit && slot_valid[i] && slot_owner[i] == req.process_id
                    && slot_page[i] == req.page_index)
                begin
                    hit  = 1'b1;
                    slot = i;
                end
            end
            if (!hit)
            begin
                // first all-zero row wins, frame 0 when none is zero
                found = 1'b0;
                slot  = 0;
                for (int i = 0; i < managed; i++)
                begin
                    if (!found && (recency[i] & cols) == '0)
                    begin
                        found = 1'b1;
                        slot  = i;
                    end
                end
                if (slot_valid[slot])
                begin
                    rsp.evicted         = 1'b1;
                    rsp.evicted_process = slot_owner[slot];
                    rsp.evicted_page    = slot_page[slot];
                end
                slot_valid[slot] = 1'b1;
                slot_owner[slot] = req.process_id;
                slot_page[slot]  = req.page_index;
                if (fault_tally != '1)
                    fault_tally++;
                rsp.fault = 1'b1;
            end
            rsp.frame = FRAME_OUT_W'(slot);
            recency[slot] |= cols;
            for (int i = 0; i < managed; i++)
                recency[i][slot] = 1'b0;
        end
        rsp.total_faults = fault_tally;
        return rsp;
    endfunction

    task automatic compare_field(string field, logic [FAULT_W-1:0] want,
                                 logic [FAULT_W-1:0] got);
        if (got !== want)
        begin
            error_tally++;
            if (error_tally <= REPORT_MAX)
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        end
    endtask

    task automatic check_response(response_t got);
        response_t want;
        if (expected_responses.size() == 0)
        begin
            error_tally++;
            if (error_tally <= REPORT_MAX)
                $display("%0t: response with none expected, expected none actual %h",
                         $time, got);
        end
        else
        begin
            want = expected_responses.pop_front();
            compare_field("fault", FAULT_W'(want.fault), FAULT_W'(got.fault));
            compare_field("frame", FAULT_W'(want.frame), FAULT_W'(got.frame));
            compare_field("evicted", FAULT_W'(want.evicted), FAULT_W'(got.evicted));
            compare_field("evicted_process", FAULT_W'(want.evicted_process),
                          FAULT_W'(got.evicted_process));
            compare_field("evicted_page", FAULT_W'(want.evicted_page),
                          FAULT_W'(got.evicted_page));
            compare_field("freed_count", FAULT_W'(want.freed_count),
                          FAULT_W'(got.freed_count));
            compare_field("total_faults", want.total_faults, got.total_faults);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_owner[i] = '0;
                slot_page[i]  = '0;
                recency[i]    = '0;
            end
            fault_tally    = '0;
            frames_setting = FRAMES_RESET;
            expected_responses.delete();
            error_tally    = 0;
            outstanding   <= 0;
            mismatches    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                frames_setting = cfg_data;
            if (done)
                check_response(response);
            if (start && !busy)
                expected_responses = {expected_responses, next_response(request)};
            outstanding <= expected_responses.size();
            mismatches  <= error_tally;
        end
    end

endmodule

FILE: tb/tb_lru_matrix_page_replacement.sv
`timescale 1ns / 100ps
// testbench top for the lru matrix page replacement block: stimulus and verdict
module tb_lru_matrix_page_replacement;
    import lrumpr_pkg::*;

    localparam int FRAMES         = 8;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int PHASE_ITEMS    = 64;
    localparam int SETTING_COUNT  = 11;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    request_t         request;
    logic             done;
    response_t        response;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    int outstanding;
    int mismatches;
    int cycle_count;
    int burst_left;
    int max_gap;

    // per-phase working set: a few processes touching a narrow band of pages
    logic [PROC_W-1:0] pid_pool [4];
    logic [PAGE_W-1:0] page_base;

    // frame counts walked through, extremes and out-of-range values included
    logic [CFG_W-1:0] frame_settings [SETTING_COUNT] =
        '{4'd1, 4'd0, 4'd15, 4'd8, 4'd3, 4'd2, 4'd7, 4'd5, 4'd4, 4'd6, 4'd8};

    lru_matrix_page_replacement #(
        .FRAMES (FRAMES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .response  (response),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // the checker sees the same channels as the block and keeps its own frame table
    lru_frame_checker #(
        .FRAMES (FRAMES)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .response    (response),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hung handshake or a lost response ends the run here
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("lru_matrix_page_replacement regression: fail");
            $finish;
        end
    end

    function automatic request_t make_req(opcode_t op, logic [PROC_W-1:0] pid,
                                          logic [PAGE_W-1:0] page);
        request_t r;
        r.opcode     = op;
        r.process_id = pid;
        r.page_index = page;
        return r;
    endfunction

    // mostly accesses inside the working set so hits and evictions both happen,
    // with some end-process transactions and some accesses from anywhere
    function automatic request_t pick_request();
        request_t r;
        int       roll;
        roll = $urandom_range(0, 99);
        r = make_req(OP_ACCESS, pid_pool[2'($urandom_range(0, 3))],
                     page_base + PAGE_W'($urandom_range(0, 5)));
        if (roll < 8)
        begin
            // end of a process; the page field is don't-care, so randomize it
            r.opcode     = OP_END;
            r.page_index = PAGE_W'($urandom);
            if (roll < 2)
                r.process_id = PROC_W'($urandom);
        end
        else if (roll < 14)
        begin
            r.process_id = PROC_W'($urandom);
            r.page_index = PAGE_W'($urandom);
        end
        return r;
    endfunction

    task automatic new_working_set();
        for (int i = 0; i < 4; i++)
            pid_pool[i] = PROC_W'($urandom);
        page_base = PAGE_W'($urandom);
    endtask

    // one transaction on the command channel; start stays high through a burst
    // and drops only for a gap, so it never falls and rises in the same step
    task automatic issue(request_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, max_gap);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        start   <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy);
    endtask

    // stop sending and wait for every predicted response, then a few more cycles
    // so a stray late response would still be caught
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_frames(logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        burst_left = 0;
        max_gap    = 6;
        new_working_set();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with the reset frame count of 8
        issue(make_req(OP_ACCESS, 8'd0,   8'd0));    // cold miss into frame 0
        issue(make_req(OP_ACCESS, 8'd255, 8'd255));  // widest ids
        issue(make_req(OP_ACCESS, 8'd0,   8'd0));    // hit
        for (int i = 1; i <= 6; i++)
            issue(make_req(OP_ACCESS, 8'd1, PAGE_W'(i)));  // fill the remaining frames
        issue(make_req(OP_ACCESS, 8'd2,   8'd0));    // full: evicts the least recent
        issue(make_req(OP_ACCESS, 8'd0,   8'd0));    // hit after eviction
        issue(make_req(OP_ACCESS, 8'd255, 8'd255));  // refault of the evicted page
        issue(make_req(OP_END,    8'd1,   8'd255));  // frees several frames
        issue(make_req(OP_END,    8'd1,   8'd0));    // nothing left to free
        issue(make_req(OP_ACCESS, 8'd128, 8'd128));  // lands where the lru row says
        issue(make_req(OP_ACCESS, 8'd1,   8'd1));
        issue(make_req(OP_END,    8'd0,   8'd0));
        issue(make_req(OP_ACCESS, 8'd0,   8'd255));
        issue(make_req(OP_END,    8'd77,  8'd170));  // unknown process
        issue(make_req(OP_ACCESS, 8'd255, 8'd0));
        drain();

        // random phases, each under its own frame count; shrinking and growing the
        // count leaves stale matrix bits, which is how the no-zero-row case shows up
        for (int p = 0; p < SETTING_COUNT + 2; p++)
        begin
            if (p < SETTING_COUNT)
                set_frames(frame_settings[p]);
            else
                set_frames(CFG_W'($urandom_range(0, 15)));
            new_working_set();
            max_gap = (p % 3 == 0) ? 0 : 6;
            for (int i = 0; i < PHASE_ITEMS; i++)
                issue(pick_request());
            drain();
        end

        // a short random tail with the widest out-of-range frame count
        set_frames(4'd15);
        max_gap = 6;
        new_working_set();
        for (int i = 0; i < 40; i++)
            issue(pick_request());
        drain();

        if (mismatches == 0)
            $display("lru_matrix_page_replacement regression: pass");
        else
            $display("lru_matrix_page_replacement regression: fail");
        $finish;
    end

endmodule
